[rtl/lbs_pkg.sv]
// Shared constants, types and state codes for the bitonic subsequence block.
package lbs_pkg;
   localparam int MAX_ITEMS  = 1024;
   localparam int VALUE_BITS = 16;
   localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
   localparam int CNT_BITS   = ADDR_BITS + 1;
   localparam int OUT_BITS   = 10;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_BWD_START,
      ST_BWD_READ,
      ST_BWD_SEARCH,
      ST_BWD_WRITE,
      ST_FWD_START,
      ST_FWD_READ,
      ST_FWD_SEARCH,
      ST_FWD_WRITE
   } state_type;

   typedef struct packed {
      logic load_write;    // store accepted value
      logic start_pass;    // clear tail count, set position
      logic forward;       // pass direction
      logic fetch_value;   // read value (and fall length) at position
      logic search_step;   // one step of a binary search probe
      logic place;         // write tail, result length, advance position
      logic finish;        // compute result register
      logic clear_seq;     // reset item count and overflow
   } cmd_type;

   typedef struct packed {
      logic pass_done;     // no positions left in this pass
      logic search_done;   // lo == hi, no probe pending
      logic full;          // store full
   } status_type;
endpackage

[rtl/lbs_datapath.sv]
// Datapath: value, fall and tail stores, binary search and best length.
module lbs_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  lbs_pkg::cmd_type                cmd,
   output lbs_pkg::status_type             status,
   input  logic [15:0]                     req_value,
   output logic [lbs_pkg::OUT_BITS-1:0]    removed_count,
   output logic                            overflow
);
   import lbs_pkg::*;

   logic [VALUE_BITS-1:0] value_mem [MAX_ITEMS];
   logic [CNT_BITS-1:0]   fall_mem  [MAX_ITEMS];
   logic [VALUE_BITS-1:0] tail_mem  [MAX_ITEMS];

   logic [CNT_BITS-1:0]   item_count_ff, tail_count_ff, pos_ff, best_ff;
   logic [CNT_BITS-1:0]   lo_ff, hi_ff;
   logic                  ovf_ff;
   logic [VALUE_BITS-1:0] cur_ff, tail_rd_ff;
   logic [CNT_BITS-1:0]   fall_rd_ff;
   logic                  probe_ff;     // tail_rd_ff holds the probe at mid_ff
   logic [CNT_BITS-1:0]   mid_ff;
   logic [OUT_BITS-1:0]   removed_ff;
   logic                  ovf_out_ff;

   logic [ADDR_BITS-1:0]  rd_addr;
   logic [CNT_BITS-1:0]   mid;
   logic [CNT_BITS-1:0]   total;

   // current position: backward pass walks down via pos-1
   assign rd_addr = cmd.forward ? pos_ff[ADDR_BITS-1:0]
                                : ADDR_BITS'(pos_ff - CNT_BITS'(1));
   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign total   = lo_ff + fall_rd_ff;   // rise + fall - 1, rise = lo+1

   assign status.pass_done   = cmd.forward ? (pos_ff == item_count_ff)
                                           : (pos_ff == '0);
   assign status.search_done = (lo_ff == hi_ff) && !probe_ff;
   assign status.full        = (item_count_ff == CNT_BITS'(MAX_ITEMS));

   always_ff @(posedge clock) begin
      if (cmd.load_write && !status.full)
         value_mem[item_count_ff[ADDR_BITS-1:0]] <= req_value[VALUE_BITS-1:0];
      if (cmd.fetch_value) begin
         cur_ff     <= value_mem[rd_addr];
         fall_rd_ff <= fall_mem[rd_addr];
      end
      tail_rd_ff <= tail_mem[mid[ADDR_BITS-1:0]];
      mid_ff     <= mid;
      if (cmd.place) begin
         if (lo_ff < CNT_BITS'(MAX_ITEMS))
            tail_mem[lo_ff[ADDR_BITS-1:0]] <= cur_ff;
         if (!cmd.forward)
            fall_mem[rd_addr] <= lo_ff + CNT_BITS'(1);
      end
      if (cmd.finish) begin
         removed_ff <= OUT_BITS'(item_count_ff - best_ff);
         ovf_out_ff <= ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_count_ff <= '0;
         tail_count_ff <= '0;
         pos_ff        <= '0;
         best_ff       <= '0;
         lo_ff         <= '0;
         hi_ff         <= '0;
         ovf_ff        <= 1'b0;
         probe_ff      <= 1'b0;
      end else begin
         if (cmd.load_write) begin
            if (status.full) ovf_ff <= 1'b1;
            else             item_count_ff <= item_count_ff + CNT_BITS'(1);
         end
         if (cmd.start_pass) begin
            tail_count_ff <= '0;
            pos_ff        <= cmd.forward ? '0 : item_count_ff;
            if (cmd.forward) best_ff <= '0;
         end
         if (cmd.fetch_value) begin
            lo_ff    <= '0;
            hi_ff    <= tail_count_ff;
            probe_ff <= 1'b0;
         end
         // probe: issue read into tail_rd_ff, then compare
         if (cmd.search_step) begin
            if (!probe_ff) probe_ff <= 1'b1;
            else begin
               probe_ff <= 1'b0;
               if (tail_rd_ff >= cur_ff) hi_ff <= mid_ff;
               else                      lo_ff <= mid_ff + CNT_BITS'(1);
            end
         end
         if (cmd.place) begin
            if (lo_ff == tail_count_ff && lo_ff < CNT_BITS'(MAX_ITEMS))
               tail_count_ff <= tail_count_ff + CNT_BITS'(1);
            pos_ff <= cmd.forward ? pos_ff + CNT_BITS'(1) : pos_ff - CNT_BITS'(1);
            if (cmd.forward && total > best_ff) best_ff <= total;
         end
         if (cmd.clear_seq) begin
            item_count_ff <= '0;
            ovf_ff        <= 1'b0;
         end
      end
   end

   assign removed_count = removed_ff;
   assign overflow      = ovf_out_ff;
endmodule

[rtl/lbs_controller.sv]
// Controller: sequences load, two search passes and result hand-off.
module lbs_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_last_item,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  lbs_pkg::status_type status,
   output lbs_pkg::cmd_type    cmd
);
   import lbs_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_stall    = 1'b1;
      rsp_valid_in = rsp_valid_ff && rsp_stall;   // drops once taken
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load_write = 1'b1;
               if (req_last_item) state_in = ST_BWD_START;
            end
         end
         ST_BWD_START: begin
            cmd.start_pass = 1'b1;
            state_in       = ST_BWD_READ;
         end
         ST_BWD_READ: begin
            if (status.pass_done) state_in = ST_FWD_START;
            else begin
               cmd.fetch_value = 1'b1;
               state_in        = ST_BWD_SEARCH;
            end
         end
         ST_BWD_SEARCH: begin
            if (status.search_done) state_in = ST_BWD_WRITE;
            else cmd.search_step = 1'b1;
         end
         ST_BWD_WRITE: begin
            cmd.place = 1'b1;
            state_in  = ST_BWD_READ;
         end
         ST_FWD_START: begin
            cmd.forward    = 1'b1;
            cmd.start_pass = 1'b1;
            state_in       = ST_FWD_READ;
         end
         ST_FWD_READ: begin
            cmd.forward = 1'b1;
            if (status.pass_done) begin
               // wait here while the previous result still sits in its register
               if (!rsp_valid_ff || !rsp_stall) begin
                  cmd.finish    = 1'b1;
                  cmd.clear_seq = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = ST_LOAD;
               end
            end else begin
               cmd.fetch_value = 1'b1;
               state_in        = ST_FWD_SEARCH;
            end
         end
         ST_FWD_SEARCH: begin
            cmd.forward = 1'b1;
            if (status.search_done) state_in = ST_FWD_WRITE;
            else cmd.search_step = 1'b1;
         end
         ST_FWD_WRITE: begin
            cmd.forward = 1'b1;
            cmd.place   = 1'b1;
            state_in    = ST_FWD_READ;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

[rtl/longest_bitonic_subsequence.sv]
// Top level of the longest bitonic subsequence block.
//
//   channel | ports                                   | direction
//   req     | req_valid req_stall req_value req_last_item | in
//   rsp     | rsp_valid rsp_stall rsp_removed_count rsp_overflow | out
//
// Loading accepts one transaction per cycle while in the load state; the request
// stalls otherwise. After the marked transaction, two passes run over the stored
// values; per pass each value is read, searched with p binary search probes, p at
// most ceil(log2(tails+1)), over the single-port tail memory (one probe = read
// then compare), and written. The result is valid the cycle after the finish.
// The result waits in its register under stall while the next sequence loads;
// a later sequence holds at its finish until that register frees. Reset is
// synchronous and clears counters and state only; memories need no clearing.
module longest_bitonic_subsequence (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_value,
   input  logic        req_last_item,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_removed_count,
   output logic        rsp_overflow
);
   import lbs_pkg::*;

   cmd_type    cmd;
   status_type status;

   lbs_controller u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .req_last_item,
      .rsp_valid, .rsp_stall, .status, .cmd
   );

   lbs_datapath u_dp (
      .clock, .reset, .cmd, .status, .req_value,
      .removed_count(rsp_removed_count), .overflow(rsp_overflow)
   );
endmodule

[sim/lbs_checker.sv]
// Checker for the bitonic subsequence block: watches both channels, predicts, compares.
`timescale 1ns / 100ps
module lbs_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [15:0] req_value,
   input  logic        req_last_item,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [9:0]  rsp_removed_count,
   input  logic        rsp_overflow,
   output int          fail_count,
   output int          pending_count
);
   import lbs_pkg::*;

   typedef struct packed {
      logic [9:0] removed_count;
      logic       overflow;
   } verdict_type;

   logic [VALUE_BITS-1:0] seq_values [MAX_ITEMS];
   int unsigned           fall_len [MAX_ITEMS];
   logic [VALUE_BITS-1:0] tails [MAX_ITEMS];
   int unsigned           tail_cnt;
   int unsigned           seq_len;
   bit                    seq_dropped;
   verdict_type           expected_q [$];

   // binary search for first tail not below v; returns run length ending at v
   function automatic int unsigned tail_insert(logic [VALUE_BITS-1:0] v);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = tail_cnt;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (tails[ADDR_BITS'(mid)] >= v) hi = mid;
         else lo = mid + 1;
      end
      if (lo < MAX_ITEMS) begin
         tails[ADDR_BITS'(lo)] = v;
         if (lo == tail_cnt) tail_cnt++;
      end
      return lo + 1;
   endfunction

   function automatic int unsigned longest_bitonic();
      int unsigned best, rise, total;
      best = 0;
      tail_cnt = 0;
      for (int i = int'(seq_len) - 1; i >= 0; i--)
         fall_len[ADDR_BITS'(i)] = tail_insert(seq_values[ADDR_BITS'(i)]);
      tail_cnt = 0;
      for (int i = 0; i < int'(seq_len); i++) begin
         rise  = tail_insert(seq_values[ADDR_BITS'(i)]);
         total = rise + fall_len[ADDR_BITS'(i)] - 1;
         if (total > best) best = total;
      end
      return best;
   endfunction

   always @(posedge clock) begin
      verdict_type exp_v;
      if (reset) begin
         seq_len       = 0;
         seq_dropped   = 0;
         fail_count    = 0;
         expected_q.delete();
         pending_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected transaction: removed=%0d overflow=%0b",
                           rsp_removed_count, rsp_overflow);
            end else begin
               exp_v = expected_q.pop_front();
               if (exp_v.removed_count !== rsp_removed_count ||
                   exp_v.overflow !== rsp_overflow) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch: removed exp %0d got %0d, overflow exp %0b got %0b",
                              exp_v.removed_count, rsp_removed_count,
                              exp_v.overflow, rsp_overflow);
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (seq_len < MAX_ITEMS) begin
               seq_values[ADDR_BITS'(seq_len)] = req_value;
               seq_len++;
            end else begin
               seq_dropped = 1;
            end
            if (req_last_item) begin
               exp_v.removed_count = 10'(seq_len - longest_bitonic());
               exp_v.overflow      = seq_dropped;
               expected_q          = {expected_q, exp_v};
               seq_len     = 0;
               seq_dropped = 0;
            end
         end
         pending_count = expected_q.size();
      end
   end
endmodule

[sim/tb.sv]
// Testbench top: drives sequences into the bitonic block and gives the verdict.
`timescale 1ns / 100ps
module tb;
   import lbs_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int DRAIN_CYCLES   = 200;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [15:0] req_value;
   logic        req_last_item;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [9:0]  rsp_removed_count;
   logic        rsp_overflow;
   int          fail_count;
   int          pending_count;

   bit          quiet_phase;   // no idling near the end
   bit          hold_rsp;      // long receiver hold-off request
   int          idle_cycles;

   longest_bitonic_subsequence u_top (.*);

   lbs_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // One transaction: offer it, with optional idle burst first, and wait
   // until it is accepted. Payload holds steady while stalled; stall is
   // looked at on the falling edge, where it is settled for the next edge.
   task automatic send_value(input logic [15:0] v, input logic last);
      int gap;
      if (!quiet_phase && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1;
      req_value     <= v;
      req_last_item <= last;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   // Random sequence; shape picks a flavor that stresses the search.
   task automatic send_sequence(input int len);
      int shape, peak;
      logic [15:0] v;
      shape = $urandom_range(0, 4);
      peak  = $urandom_range(0, len - 1);
      for (int i = 0; i < len; i++) begin
         case (shape)
            0: v = 16'($urandom);
            1: v = 16'($urandom_range(0, 7));                 // many ties
            2: v = 16'((i <= peak) ? i * 3 : (len - i) * 3);   // clean hill
            3: v = 16'((i <= peak) ? 1000 + i : 1000 + peak - (i - peak)
                       + $urandom_range(0, 2));
            default: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         endcase
         send_value(v, i == len - 1);
      end
   endtask

   // Receiver: random stall bursts, plus one long hold-off on request.
   initial begin
      int n;
      bit held;
      held      = 0;
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_rsp && !held) begin
            held = 1;
            rsp_stall <= 1;
            repeat (400) @(posedge clock);
            rsp_stall <= 0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 12);
            rsp_stall <= 1;
            repeat (n) @(posedge clock);
            rsp_stall <= 0;
         end else begin
            rsp_stall <= 0;
         end
      end
   end

   // Watchdog: cycles with no accepted transaction on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int sent;
      reset         = 1;
      req_valid     = 0;
      req_value     = 0;
      req_last_item = 0;
      quiet_phase   = 0;
      hold_rsp      = 0;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: single values at extremes, and walking bits
      send_value(16'h0000, 1);
      send_value(16'hFFFF, 1);
      for (int b = 0; b < 16; b += 4) begin
         send_value(16'(1 << b), 0);
         send_value(~16'(1 << b), 0);
         send_value(16'(1 << b), 1);
      end
      send_value(16'd5, 0);             // equal pair at the peak
      send_value(16'd5, 1);
      send_value(16'd1, 0);             // rise, equal pair at the top, then fall
      send_value(16'd9, 0);
      send_value(16'd9, 0);
      send_value(16'd2, 1);

      // overflow: fill the store, then overrun, ending on a dropped mark
      for (int i = 0; i < MAX_ITEMS + 3; i++)
         send_value(16'($urandom_range(0, 40)), i == MAX_ITEMS + 2);

      // pressure: receiver holds off while the sender keeps offering
      hold_rsp = 1;
      send_sequence(3);
      send_sequence(4);
      send_sequence(2);

      sent = 0;
      while (sent < 320) begin
         int len;
         len = ($urandom_range(0, 20) == 0) ? $urandom_range(30, 120)
                                             : $urandom_range(1, 12);
         if (sent > 240) quiet_phase = 1;
         send_sequence(len);
         sent += len;
      end
      req_valid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
